// ===== hdl/ppqhs_pkg.sv =====
package ppqhs_pkg;

   localparam int NUM_POSITIONS_DEF = 512;
   localparam int NUM_BINS_DEF      = 128;
   localparam int NUM_CLASSES       = 6;

   localparam int COUNT_W = 32;
   localparam int SUM_W   = 48;

   localparam logic [0:0] OP_ADD    = 1'b0;
   localparam logic [0:0] OP_REPORT = 1'b1;

   localparam logic signed [7:0] MIN_EMPTY = 8'sd100;
   localparam logic signed [7:0] MAX_EMPTY = -8'sd100;

   // Slot record held in the slot memory.
   typedef struct packed {
      logic [COUNT_W-1:0]  cnt;
      logic signed [7:0]   mn;
      logic signed [7:0]   mx;
      logic [SUM_W-1:0]    sum;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR0,
      ST_ADD_WR1,
      ST_REP_RD,
      ST_REP_WALK,
      ST_REP_FIN,
      ST_REP_OUT
   } state_type;

   // Class index of an ASCII letter; zero for anything else.
   function automatic logic [2:0] letter_class(input logic [7:0] ch);
      logic [2:0] c;
      unique case (ch)
         8'h41, 8'h61: c = 3'd1;
         8'h43, 8'h63: c = 3'd2;
         8'h47, 8'h67: c = 3'd3;
         8'h54, 8'h74: c = 3'd4;
         8'h4E, 8'h6E: c = 3'd5;
         default:      c = 3'd0;
      endcase
      return c;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_add32(input logic [COUNT_W-1:0] a,
                                                    input logic [19:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {{(COUNT_W-19){1'b0}}, b};
      return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
   endfunction

endpackage

// ===== hdl/ppqhs_ram.sv =====
module ppqhs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/ppqhs_box.sv =====
// Box-plot figures from the quartiles, minimum and maximum, registered once.
module ppqhs_box (
   input  logic                clock,
   input  logic signed [7:0]   q1,
   input  logic signed [7:0]   q3,
   input  logic signed [7:0]   mn,
   input  logic signed [7:0]   mx,
   output logic signed [8:0]   iqr_ff,
   output logic signed [9:0]   lw_ff,
   output logic signed [9:0]   rw_ff
);

   logic signed [8:0]  iqr;
   logic signed [10:0] t3;
   logic signed [10:0] t;
   logic signed [10:0] lo;
   logic signed [10:0] hi;

   always_comb begin
      iqr = 9'(q3) - 9'(q1);
      t3  = 11'(iqr) * 11'sd3;
      // Truncation toward zero.
      t   = (t3 < 0) ? -((-t3) >>> 1) : (t3 >>> 1);
      lo  = 11'(q1) - t;
      hi  = 11'(q3) + t;
   end

   always_ff @(posedge clock) begin
      iqr_ff <= iqr;
      lw_ff  <= (lo < 11'(mn)) ? 10'(mn) : lo[9:0];
      rw_ff  <= (hi > 11'(mx)) ? 10'(mx) : hi[9:0];
   end

endmodule

// ===== hdl/per_position_quality_histogram_stats_unit.sv =====
// Per-position quality statistics unit.
//
// Items arrive on the req_ stream; req_tuser says whether a transfer is an add
// or a report. An add transfer updates the count and, when has_quality is set,
// the min, max, weighted sum and quality histogram of class ALL and of the
// letter's class at one position, and produces no result. A report transfer
// of class zero to five returns one rsp_ transfer with the count, min, max,
// sum, quartiles, IQR, whiskers and the ALL count of position zero. The csr_
// channel writes the quality that maps to histogram bin zero; the user must
// write it only while the unit is idle, as the unit does not enforce this.
// An add passes through ADD_RD, in which the ALL slot and bin arrive and the
// letter slot and bin are read, ADD_WR0, which writes the ALL slot, and
// ADD_WR1, which writes the letter slot and is skipped when the letter is not
// A, C, G, T or N; the next item is taken after that.
// A report passes through REP_RD, the walk over the histogram in REP_WALK,
// which reads one bin per cycle, REP_FIN and REP_OUT, which loads the output
// register; the next item can be taken after that.
// After reset the unit clears its memories, one histogram bin per cycle, while
// req_tready stays low.
// A result sits in an output register until taken; while the receiver
// stalls, the next item is still accepted and worked on, but its result
// waits for the register to empty.
module per_position_quality_histogram_stats_unit #(
   parameter int NUM_POSITIONS = ppqhs_pkg::NUM_POSITIONS_DEF,
   parameter int NUM_BINS      = ppqhs_pkg::NUM_BINS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tuser: operation[0]
   input  logic [0:0]   req_tuser,
   // tdata: position[8:0], base_char[16:9], report_class[19:17],
   // quality[27:20], has_quality[28], read_weight[48:29], zeros [55:49]
   input  logic [55:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: base_count[31:0], min_seen[39:32], max_seen[47:40],
   // quality_sum[95:48], first_quartile[103:96], median_value[111:104],
   // third_quartile[119:112], quartile_range[128:120], left_whisker[138:129],
   // right_whisker[148:139], first_position_count[180:149], zeros [183:181]
   output logic [183:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   localparam int SLOTS     = NUM_POSITIONS * ppqhs_pkg::NUM_CLASSES;
   localparam int SLOT_AW   = $clog2(SLOTS);
   localparam int BIN_AW    = $clog2(NUM_BINS);
   localparam int HIST_AW   = SLOT_AW + BIN_AW;
   localparam int HIST_DEPTH = SLOTS * (1 << BIN_AW);
   localparam int COUNT_W_L = 34;

   // Request fields.
   logic               f_op;
   logic [8:0]         f_pos;
   logic [7:0]         f_char;
   logic [2:0]         f_cls;
   logic signed [7:0]  f_q;
   logic               f_hasq;
   logic [19:0]        f_w;
   assign f_op   = req_tuser[0];
   assign f_pos  = req_tdata[8:0];
   assign f_char = req_tdata[16:9];
   assign f_cls  = req_tdata[19:17];
   assign f_q    = req_tdata[27:20];
   assign f_hasq = req_tdata[28];
   assign f_w    = req_tdata[48:29];

   ppqhs_pkg::state_type state_ff, state_in;

   logic signed [7:0]   lowq_ff;
   logic [SLOT_AW-1:0]  clr_ff, clr_in;
   logic [SLOT_AW-1:0]  base_ff, base_in;     // slot of class ALL or report slot
   logic [2:0]          cls_ff, cls_in;
   logic [BIN_AW-1:0]   bin_ff, bin_in;
   logic signed [7:0]   qc_ff, qc_in;
   logic                hasq_ff, hasq_in;
   logic [19:0]         w_ff, w_in;
   logic                empty_ff, empty_in;
   logic [BIN_AW:0]     walk_ff, walk_in;
   logic [COUNT_W_L-1:0] acc_ff, acc_in;
   logic                f1_ff, f1_in, f2_ff, f2_in, f3_ff, f3_in;
   logic signed [7:0]   q1_ff, q1_in, md_ff, md_in, q3_ff, q3_in;
   logic [ppqhs_pkg::COUNT_W-1:0] fpc_ff, fpc_in;
   ppqhs_pkg::slot_type slot0_ff, slot0_in;    // ALL slot read in add
   ppqhs_pkg::slot_type slot1_ff, slot1_in;    // letter slot read in add
   logic [31:0]         h0_ff, h0_in;          // ALL bin read in add
   logic [31:0]         h1_ff, h1_in;          // letter bin read in add
   logic                out_v_ff, out_v_in;
   logic [183:0]        out_d_ff, out_d_in;

   // Slot memory. An add reads its two slots one after the other.
   logic                slot_we;
   logic [SLOT_AW-1:0]  slot_wa;
   ppqhs_pkg::slot_type slot_wd;
   logic [SLOT_AW-1:0]  slot_ra0;
   logic [ppqhs_pkg::SLOT_W-1:0] slot_rd0;

   ppqhs_ram #(.WIDTH(ppqhs_pkg::SLOT_W), .DEPTH(SLOTS)) u_slot0 (
      .clock, .wr_en(slot_we), .wr_addr(slot_wa), .wr_data(slot_wd),
      .rd_addr(slot_ra0), .rd_data(slot_rd0));

   // Histogram memory, one row of bins per slot.
   logic                hist_we;
   logic [HIST_AW-1:0]  hist_wa;
   logic [31:0]         hist_wd;
   logic [HIST_AW-1:0]  hist_ra0;
   logic [31:0]         hist_rd0;
   logic                hist_clr;

   ppqhs_ram #(.WIDTH(32), .DEPTH(HIST_DEPTH)) u_hist0 (
      .clock, .wr_en(hist_we), .wr_addr(hist_wa), .wr_data(hist_wd),
      .rd_addr(hist_ra0), .rd_data(hist_rd0));

   // Clearing pass walks histogram rows with a bin counter per slot.
   logic [BIN_AW-1:0]   cbin_ff, cbin_in;

   ppqhs_pkg::slot_type rd0;
   assign rd0 = ppqhs_pkg::slot_type'(slot_rd0);

   // Add-path arithmetic for the slot being written.
   ppqhs_pkg::slot_type upd_src, upd;
   logic [31:0]         hsrc;
   logic signed [29:0]  prod;
   logic signed [50:0]  tsum;

   always_comb begin
      upd_src = (state_ff == ppqhs_pkg::ST_ADD_WR0) ? slot0_ff : slot1_ff;
      hsrc    = (state_ff == ppqhs_pkg::ST_ADD_WR0) ? h0_ff : h1_ff;
      upd     = upd_src;
      prod    = 30'(qc_ff) * $signed({10'd0, w_ff});
      tsum    = $signed({3'd0, upd_src.sum}) + 51'(prod);
      upd.cnt = ppqhs_pkg::sat_add32(upd_src.cnt, w_ff);
      if (hasq_ff) begin
         if (qc_ff < upd_src.mn) upd.mn = qc_ff;
         if (qc_ff > upd_src.mx) upd.mx = qc_ff;
         if (tsum < 0) upd.sum = '0;
         else if (tsum > $signed({3'd0, {ppqhs_pkg::SUM_W{1'b1}}}))
            upd.sum = {ppqhs_pkg::SUM_W{1'b1}};
         else upd.sum = tsum[ppqhs_pkg::SUM_W-1:0];
      end
   end

   // Quality clamp and bin.
   logic signed [9:0] bin_raw;
   logic [BIN_AW-1:0] bin_c;
   always_comb begin
      bin_raw = 10'(f_q) - 10'(lowq_ff);
      if (bin_raw < 0) bin_c = '0;
      else if (bin_raw > 10'(NUM_BINS - 1)) bin_c = BIN_AW'(NUM_BINS - 1);
      else bin_c = bin_raw[BIN_AW-1:0];
   end

   logic [SLOT_AW-1:0] req_slot;
   assign req_slot = SLOT_AW'(32'(f_pos) * ppqhs_pkg::NUM_CLASSES);

   // Walk: bin value and accumulated weight.
   logic signed [9:0]  bval_w;
   logic signed [7:0]  bval;
   logic [COUNT_W_L-1:0] acc_nx;
   logic [COUNT_W_L-1:0] n1, n2, n3;
   always_comb begin
      bval_w = 10'(lowq_ff) + 10'($signed({1'b0, walk_ff[BIN_AW-1:0]}));
      if (bval_w > 10'sd127) bval = 8'sd127;
      else if (bval_w < -10'sd128) bval = -8'sd128;
      else bval = bval_w[7:0];
      acc_nx = acc_ff + {2'd0, hist_rd0};
      n1 = {2'd0, slot0_ff.cnt} >> 2;
      n2 = {2'd0, slot0_ff.cnt} >> 1;
      n3 = ({2'd0, slot0_ff.cnt} + {1'b0, slot0_ff.cnt, 1'b0}) >> 2;
   end

   logic rsp_take;
   assign rsp_take = out_v_ff && rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ppqhs_pkg::ST_CLEAR:
            if (cbin_ff == BIN_AW'(NUM_BINS - 1) && clr_ff == SLOT_AW'(SLOTS - 1))
               state_in = ppqhs_pkg::ST_IDLE;
         ppqhs_pkg::ST_IDLE:
            if (req_tvalid) begin
               if (f_op == ppqhs_pkg::OP_ADD)
                  state_in = (32'(f_pos) < NUM_POSITIONS) ? ppqhs_pkg::ST_ADD_RD
                                                          : ppqhs_pkg::ST_IDLE;
               else if (f_cls < 3'(ppqhs_pkg::NUM_CLASSES))
                  state_in = ppqhs_pkg::ST_REP_RD;
            end
         ppqhs_pkg::ST_ADD_RD:  state_in = ppqhs_pkg::ST_ADD_WR0;
         ppqhs_pkg::ST_ADD_WR0:
            state_in = (cls_ff != 3'd0) ? ppqhs_pkg::ST_ADD_WR1 : ppqhs_pkg::ST_IDLE;
         ppqhs_pkg::ST_ADD_WR1: state_in = ppqhs_pkg::ST_IDLE;
         ppqhs_pkg::ST_REP_RD:  state_in = ppqhs_pkg::ST_REP_WALK;
         ppqhs_pkg::ST_REP_WALK:
            if (walk_ff == (BIN_AW+1)'(NUM_BINS - 1)) state_in = ppqhs_pkg::ST_REP_FIN;
         ppqhs_pkg::ST_REP_FIN: state_in = ppqhs_pkg::ST_REP_OUT;
         ppqhs_pkg::ST_REP_OUT:
            if (!out_v_ff || rsp_take) state_in = ppqhs_pkg::ST_IDLE;
         default: state_in = ppqhs_pkg::ST_CLEAR;
      endcase
   end

   ppqhs_pkg::slot_type clr_slot;
   always_comb begin
      clr_slot.cnt = '0;
      clr_slot.mn  = ppqhs_pkg::MIN_EMPTY;
      clr_slot.mx  = ppqhs_pkg::MAX_EMPTY;
      clr_slot.sum = '0;
   end

   logic signed [8:0] box_iqr;
   logic signed [9:0] box_lw, box_rw;
   logic signed [7:0] fin_q1, fin_md, fin_q3;

   ppqhs_box u_box (
      .clock, .q1(fin_q1), .q3(fin_q3), .mn(slot0_ff.mn), .mx(slot0_ff.mx),
      .iqr_ff(box_iqr), .lw_ff(box_lw), .rw_ff(box_rw));

   always_comb begin
      fin_q1 = (n1 == '0) ? slot0_ff.mn : (f1_ff ? q1_ff : slot0_ff.mx);
      fin_md = (n2 == '0) ? slot0_ff.mn : (f2_ff ? md_ff : slot0_ff.mx);
      fin_q3 = (n3 == '0) ? slot0_ff.mn : (f3_ff ? q3_ff : slot0_ff.mx);
   end

   // Datapath and memory control.
   always_comb begin
      req_tready = (state_ff == ppqhs_pkg::ST_IDLE);
      csr_ready  = 1'b1;
      clr_in   = clr_ff;
      cbin_in  = cbin_ff;
      base_in  = base_ff;
      cls_in   = cls_ff;
      bin_in   = bin_ff;
      qc_in    = qc_ff;
      hasq_in  = hasq_ff;
      w_in     = w_ff;
      empty_in = empty_ff;
      walk_in  = walk_ff;
      acc_in   = acc_ff;
      f1_in = f1_ff; f2_in = f2_ff; f3_in = f3_ff;
      q1_in = q1_ff; md_in = md_ff; q3_in = q3_ff;
      fpc_in   = fpc_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      h0_in    = h0_ff;
      h1_in    = h1_ff;
      out_v_in = out_v_ff && !rsp_take;
      out_d_in = out_d_ff;
      hist_clr = 1'b0;
      slot_we  = 1'b0;
      slot_wa  = base_ff;
      slot_wd  = upd;
      slot_ra0 = req_slot;
      hist_we  = 1'b0;
      hist_wa  = {base_ff, bin_ff};
      hist_wd  = ppqhs_pkg::sat_add32(hsrc, w_ff);
      hist_ra0 = {req_slot, bin_c};
      unique case (state_ff)
         ppqhs_pkg::ST_CLEAR: begin
            hist_clr = 1'b1;
            hist_we  = 1'b1;
            hist_wa  = {clr_ff, cbin_ff};
            hist_wd  = '0;
            slot_we  = 1'b1;
            slot_wa  = clr_ff;
            slot_wd  = clr_slot;
            cbin_in  = (cbin_ff == BIN_AW'(NUM_BINS - 1)) ? '0 : cbin_ff + BIN_AW'(1);
            if (cbin_ff == BIN_AW'(NUM_BINS - 1)) clr_in = clr_ff + SLOT_AW'(1);
            fpc_in   = '0;
         end
         ppqhs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               base_in  = (f_op == ppqhs_pkg::OP_ADD) ? req_slot : req_slot + SLOT_AW'(f_cls);
               cls_in   = ppqhs_pkg::letter_class(f_char);
               bin_in   = bin_c;
               qc_in    = 8'(10'(lowq_ff) + 10'(bin_c));
               hasq_in  = f_hasq;
               w_in     = f_w;
               empty_in = !(32'(f_pos) < NUM_POSITIONS);
               slot_ra0 = (f_op == ppqhs_pkg::OP_ADD) ? req_slot : req_slot + SLOT_AW'(f_cls);
            end
         end
         ppqhs_pkg::ST_ADD_RD: begin
            // The ALL slot and bin arrive; the letter slot and bin are read next.
            slot0_in = rd0;
            h0_in    = hist_rd0;
            slot_ra0 = base_ff + SLOT_AW'(cls_ff);
            hist_ra0 = {base_ff + SLOT_AW'(cls_ff), bin_ff};
         end
         ppqhs_pkg::ST_ADD_WR0: begin
            slot1_in = rd0;
            h1_in    = hist_rd0;
            slot_we = 1'b1;
            hist_we = hasq_ff;
            if (base_ff == SLOT_AW'(0)) fpc_in = upd.cnt;
         end
         ppqhs_pkg::ST_ADD_WR1: begin
            slot_we = 1'b1;
            slot_wa = base_ff + SLOT_AW'(cls_ff);
            hist_we = hasq_ff;
            hist_wa = {slot_wa, bin_ff};
         end
         ppqhs_pkg::ST_REP_RD: begin
            slot0_in = empty_ff ? clr_slot : rd0;
            walk_in  = '0;
            acc_in   = '0;
            f1_in = 1'b0; f2_in = 1'b0; f3_in = 1'b0;
            hist_ra0 = {base_ff, BIN_AW'(0)};
         end
         ppqhs_pkg::ST_REP_WALK: begin
            hist_ra0 = {base_ff, BIN_AW'(walk_ff + 1'b1)};
            walk_in  = walk_ff + 1'b1;
            if (!empty_ff) begin
               acc_in = acc_nx;
               if (!f1_ff && acc_nx > n1) begin f1_in = 1'b1; q1_in = bval; end
               if (!f2_ff && acc_nx > n2) begin f2_in = 1'b1; md_in = bval; end
               if (!f3_ff && acc_nx > n3) begin f3_in = 1'b1; q3_in = bval; end
            end
         end
         ppqhs_pkg::ST_REP_FIN: begin
            q1_in = fin_q1; md_in = fin_md; q3_in = fin_q3;
         end
         ppqhs_pkg::ST_REP_OUT: begin
            if (!out_v_ff || rsp_take) begin
               out_v_in = 1'b1;
               out_d_in = {3'd0, fpc_ff, box_rw, box_lw, box_iqr, q3_ff, md_ff, q1_ff,
                           slot0_ff.sum, slot0_ff.mx, slot0_ff.mn, slot0_ff.cnt};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppqhs_pkg::ST_CLEAR;
         clr_ff   <= '0;
         cbin_ff  <= '0;
         out_v_ff <= 1'b0;
         lowq_ff  <= -8'sd40;
         fpc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         cbin_ff  <= cbin_in;
         out_v_ff <= out_v_in;
         fpc_ff   <= fpc_in;
         if (csr_valid && csr_ready) lowq_ff <= csr_data;
      end
      base_ff  <= base_in;
      cls_ff   <= cls_in;
      bin_ff   <= bin_in;
      qc_ff    <= qc_in;
      hasq_ff  <= hasq_in;
      w_ff     <= w_in;
      empty_ff <= empty_in;
      walk_ff  <= walk_in;
      acc_ff   <= acc_in;
      f1_ff <= f1_in; f2_ff <= f2_in; f3_ff <= f3_in;
      q1_ff <= q1_in; md_ff <= md_in; q3_ff <= q3_in;
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      h0_ff    <= h0_in;
      h1_ff    <= h1_in;
      out_d_ff <= out_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

   // A pending result is held until it is taken.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_tready |=> out_v_ff && $stable(out_d_ff))
      else $error("result changed while stalled");
   // No item is taken during the clearing pass.
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ppqhs_pkg::ST_CLEAR |-> !req_tready)
      else $error("request accepted during clear");
   // Histogram writes only happen while clearing or in add write cycles.
   a_hist_we: assert property (@(posedge clock) disable iff (reset)
      hist_we |-> hist_clr || state_ff == ppqhs_pkg::ST_ADD_WR0
                  || state_ff == ppqhs_pkg::ST_ADD_WR1)
      else $error("stray histogram write");

endmodule

// ===== sim/per_position_quality_histogram_stats_unit_tb.sv =====
`timescale 1ns / 1ps

module per_position_quality_histogram_stats_unit_tb;

   localparam int POSITIONS = 512;
   localparam int BINS      = 128;
   localparam int CLASSES   = 6;
   // The clearing pass after reset alone must fit well inside this limit.
   localparam int WATCHDOG_LIMIT = 1500000;

   // One request, operation in bit zero. The operation travels on req_tuser and
   // the fields above it, shifted down by one, on req_tdata.
   typedef struct packed {
      logic [5:0]         pad;
      logic [19:0]        read_weight;
      logic               has_quality;
      logic signed [7:0]  quality;
      logic [2:0]         report_class;
      logic [7:0]         base_char;
      logic [8:0]         position;
      logic [0:0]         operation;
   } request_item;

   // One result transfer, packed as rsp_tdata, lowest field last.
   typedef struct packed {
      logic [2:0]         pad;
      logic [31:0]        first_position_count;
      logic signed [9:0]  right_whisker;
      logic signed [9:0]  left_whisker;
      logic signed [8:0]  quartile_range;
      logic signed [7:0]  third_quartile;
      logic signed [7:0]  median_value;
      logic signed [7:0]  first_quartile;
      logic [47:0]        quality_sum;
      logic signed [7:0]  max_seen;
      logic signed [7:0]  min_seen;
      logic [31:0]        base_count;
   } report_result;

   // The scoreboard keeps its own copy of every store and predicts each report.
   class quality_stats_scoreboard;
      int                lowest;
      int unsigned       counts [POSITIONS*CLASSES];
      int                minimums [POSITIONS*CLASSES];
      int                maximums [POSITIONS*CLASSES];
      longint            sums [POSITIONS*CLASSES];
      int unsigned       histogram [POSITIONS*CLASSES*BINS];
      report_result      pending_reports [$];
      int                failures;

      function new();
         lowest = -40;
         failures = 0;
         foreach (counts[i]) begin
            counts[i] = 0;
            minimums[i] = 100;
            maximums[i] = -100;
            sums[i] = 0;
         end
         foreach (histogram[i]) histogram[i] = 0;
      endfunction

      function int unsigned add_saturating(int unsigned a, int unsigned b);
         return (a > 32'hFFFF_FFFF - b) ? 32'hFFFF_FFFF : a + b;
      endfunction

      function int letter_to_class(logic [7:0] ch);
         case (ch)
            "A", "a": return 1;
            "C", "c": return 2;
            "G", "g": return 3;
            "T", "t": return 4;
            "N", "n": return 5;
            default:  return 0;
         endcase
      endfunction

      function void record_base(int slot, int q, int bin, int unsigned w, bit hasq);
         longint t;
         counts[slot] = add_saturating(counts[slot], w);
         if (hasq) begin
            if (q < minimums[slot]) minimums[slot] = q;
            if (q > maximums[slot]) maximums[slot] = q;
            t = sums[slot] + longint'(q) * longint'(w);
            if (t < 0) t = 0;
            if (t > 64'hFFFF_FFFF_FFFF) t = 64'hFFFF_FFFF_FFFF;
            sums[slot] = t;
            histogram[slot*BINS+bin] = add_saturating(histogram[slot*BINS+bin], w);
         end
      endfunction

      function int order_statistic(int slot, longint unsigned n);
         longint unsigned acc;
         int v;
         acc = 0;
         if (n == 0) return minimums[slot];
         for (int b = 0; b < BINS; b++) begin
            acc += histogram[slot*BINS+b];
            if (acc > n) begin
               v = lowest + b;
               return (v < -128) ? -128 : (v > 127) ? 127 : v;
            end
         end
         return maximums[slot];
      endfunction

      // Called for every accepted request transfer.
      function void note_request(request_item it);
         int q, bin, cls, slot, mn, mx, q1, med, q3, iqr, t;
         report_result r;
         if (it.operation == ppqhs_pkg::OP_ADD) begin
            bin = int'(it.quality) - lowest;
            if (bin < 0) bin = 0;
            if (bin > BINS-1) bin = BINS-1;
            q = lowest + bin;
            cls = letter_to_class(it.base_char);
            record_base(it.position*CLASSES, q, bin, it.read_weight, it.has_quality);
            if (cls != 0)
               record_base(it.position*CLASSES+cls, q, bin, it.read_weight,
                           it.has_quality);
         end else if (it.report_class < CLASSES) begin
            slot = it.position*CLASSES + it.report_class;
            mn = minimums[slot];
            mx = maximums[slot];
            q1  = order_statistic(slot, longint'(counts[slot]) / 4);
            med = order_statistic(slot, longint'(counts[slot]) / 2);
            q3  = order_statistic(slot, longint'(counts[slot]) * 3 / 4);
            iqr = q3 - q1;
            t = (iqr * 3) / 2;
            r = '0;
            r.base_count = counts[slot];
            r.min_seen = 8'(mn);
            r.max_seen = 8'(mx);
            r.quality_sum = 48'(sums[slot]);
            r.first_quartile = 8'(q1);
            r.median_value = 8'(med);
            r.third_quartile = 8'(q3);
            r.quartile_range = 9'(iqr);
            r.left_whisker = 10'((q1 - t < mn) ? mn : q1 - t);
            r.right_whisker = 10'((q3 + t > mx) ? mx : q3 + t);
            r.first_position_count = counts[0];
            pending_reports.push_back(r);
         end
      endfunction

      // Called for every accepted result transfer.
      function void check_result(report_result got);
         report_result w;
         if (pending_reports.size() == 0) begin
            $error("result transfer with no report outstanding: %h", got);
            failures++;
            return;
         end
         w = pending_reports.pop_front();
         if (got.base_count !== w.base_count) begin
            $error("base_count expected %0d actual %0d", w.base_count, got.base_count);
            failures++;
         end
         if (got.min_seen !== w.min_seen) begin
            $error("min_seen expected %0d actual %0d", w.min_seen, got.min_seen);
            failures++;
         end
         if (got.max_seen !== w.max_seen) begin
            $error("max_seen expected %0d actual %0d", w.max_seen, got.max_seen);
            failures++;
         end
         if (got.quality_sum !== w.quality_sum) begin
            $error("quality_sum expected %0d actual %0d", w.quality_sum, got.quality_sum);
            failures++;
         end
         if (got.first_quartile !== w.first_quartile) begin
            $error("first_quartile expected %0d actual %0d",
                   w.first_quartile, got.first_quartile);
            failures++;
         end
         if (got.median_value !== w.median_value) begin
            $error("median_value expected %0d actual %0d", w.median_value, got.median_value);
            failures++;
         end
         if (got.third_quartile !== w.third_quartile) begin
            $error("third_quartile expected %0d actual %0d",
                   w.third_quartile, got.third_quartile);
            failures++;
         end
         if (got.quartile_range !== w.quartile_range) begin
            $error("quartile_range expected %0d actual %0d",
                   w.quartile_range, got.quartile_range);
            failures++;
         end
         if (got.left_whisker !== w.left_whisker) begin
            $error("left_whisker expected %0d actual %0d", w.left_whisker, got.left_whisker);
            failures++;
         end
         if (got.right_whisker !== w.right_whisker) begin
            $error("right_whisker expected %0d actual %0d",
                   w.right_whisker, got.right_whisker);
            failures++;
         end
         if (got.first_position_count !== w.first_position_count) begin
            $error("first_position_count expected %0d actual %0d",
                   w.first_position_count, got.first_position_count);
            failures++;
         end
         if (got.pad !== 3'b000) begin
            $error("tdata padding expected 0 actual %0d", got.pad);
            failures++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [0:0]   req_tuser;
   logic [55:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [183:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;

   quality_stats_scoreboard stats = new();
   int  results_taken = 0;
   int  idle_cycles = 0;
   bit  long_hold_done = 0;

   per_position_quality_histogram_stats_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // A 4 ns clock, high for half the period and low for the other half.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic request_item make_add(int pos, logic [7:0] ch, int q, bit hasq,
                                            int unsigned w);
      request_item it;
      it = '0;
      it.operation = ppqhs_pkg::OP_ADD;
      it.position = 9'(pos);
      it.base_char = ch;
      it.quality = 8'(q);
      it.has_quality = hasq;
      it.read_weight = 20'(w);
      // The class field is irrelevant to an add, so it carries noise.
      it.report_class = 3'($urandom_range(0, 7));
      return it;
   endfunction

   function automatic request_item make_report(int pos, int cls);
      request_item it;
      it = '0;
      it.operation = ppqhs_pkg::OP_REPORT;
      it.position = 9'(pos);
      it.report_class = 3'(cls);
      // Letter, quality and weight mean nothing to a report; they carry noise.
      it.base_char = 8'($urandom);
      it.quality = 8'($urandom);
      it.has_quality = 1'($urandom);
      it.read_weight = 20'($urandom);
      return it;
   endfunction

   // Offers one request transfer after a random gap. On return the item has been
   // accepted and req_tvalid is still high; the next call or stop_requests lowers
   // or replaces it at the following falling edge, before the next rising edge.
   task automatic send_request(request_item it);
      int gap;
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 3) == 0) gap = 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.operation;
      req_tdata <= {1'b0, it[55:1]};
      do @(posedge clock); while (!req_tready);
      stats.note_request(it);
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Waits until every outstanding report has been answered. An add gives no
   // result, so it then waits on for the last one to finish.
   task automatic drain_results();
      while (stats.pending_reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_lowest_quality(int value);
      stop_requests();
      drain_results();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= 8'(value);
      do @(posedge clock); while (!csr_ready);
      stats.lowest = $signed(csr_data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random stimulus concentrated on a handful of positions so that histograms
   // fill up and the quartile walk has real work to do.
   task automatic random_phase(int items);
      request_item it;
      logic [7:0] letters [10] = '{"A", "C", "G", "T", "N", "a", "c", "g", "t", "n"};
      int pos;
      logic [7:0] ch;
      int unsigned w;
      for (int i = 0; i < items; i++) begin
         pos = ($urandom_range(0, 4) == 0) ? $urandom_range(0, POSITIONS-1)
                                          : $urandom_range(0, 7);
         if ($urandom_range(0, 9) < 3) begin
            it = make_report(pos, ($urandom_range(0, 15) == 0) ? $urandom_range(6, 7)
                                                               : $urandom_range(0, 5));
         end else begin
            ch = ($urandom_range(0, 7) == 0) ? 8'($urandom) : letters[$urandom_range(0, 9)];
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20'hFFFFF)
                                           : $urandom_range(1, 16);
            it = make_add(pos, ch, $signed(8'($urandom)), $urandom_range(0, 7) != 0, w);
         end
         send_request(it);
      end
   endtask

   // Receiver: takes result transfers after random gaps, and once holds off for
   // a long stretch so that the output register fills and req_tready drops.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (results_taken == 30 && !long_hold_done) begin
            long_hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (1200) @(posedge clock);
            @(negedge clock);
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         stats.check_result(rsp_tdata);
         results_taken++;
      end
   end

   // Watchdog: counts cycles in which no transfer happens on any channel. The
   // clearing pass after reset and the long receiver hold stay well inside it.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      int lowest_settings [5] = '{-64, 64, 0, 0, -40};
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes of every field, every class, empty entries,
      // qualities clamped at both ends of the bins and reports of classes 6 and 7.
      write_lowest_quality(-40);
      send_request(make_report(300, 0));
      send_request(make_add(0, "A", 127, 1, 20'hFFFFF));
      send_request(make_add(0, "c", -128, 1, 1));
      send_request(make_add(0, "G", -64, 1, 3));
      send_request(make_add(0, "t", 20, 0, 5));
      send_request(make_add(0, "N", 30, 1, 7));
      send_request(make_add(0, "x", -10, 1, 9));
      send_request(make_add(511, "n", 0, 1, 20'hFFFFF));
      send_request(make_add(511, "T", -128, 1, 20'hFFFFF));
      send_request(make_add(511, 8'hFF, 127, 1, 1));
      for (int c = 0; c < 8; c++) send_request(make_report(0, c));
      send_request(make_report(511, 0));
      send_request(make_report(511, 4));
      send_request(make_report(511, 5));
      send_request(make_report(300, 3));

      // Random phases under several bin offsets, the extremes among them. Old
      // histogram contents are reported again under each new offset.
      lowest_settings[3] = int'($urandom_range(0, 128)) - 64;
      for (int p = 0; p < 5; p++) begin
         write_lowest_quality(lowest_settings[p]);
         random_phase(170);
         // Sender pauses until every result is back, then carries on.
         stop_requests();
         while (stats.pending_reports.size() != 0) @(posedge clock);
         random_phase(170);
      end
      stop_requests();

      while (stats.pending_reports.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (stats.failures == 0 && stats.pending_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
